// ===== src/glyph_coverage_index_lookup_core_defines.svh =====
// Assertion macros for the glyph coverage lookup core.
`ifndef GLYPH_COVERAGE_INDEX_LOOKUP_CORE_DEFINES_SVH
`define GLYPH_COVERAGE_INDEX_LOOKUP_CORE_DEFINES_SVH

`ifndef SYNTH
`define GCIL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define GCIL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GCIL_ASSERT_IMP(label, clk, rst, ante, cons)
`define GCIL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/gcil_pkg.sv =====
`default_nettype none

package gcil_pkg;

   localparam int GCIL_MAX_ENTRIES = 1024;
   localparam int GLYPH_W          = 16;
   localparam int COV_W            = 17;
   localparam int IDX_W            = 10;
   localparam int CSR_DATA_W       = 11;
   localparam int CSR_IDX_W        = 1;

   localparam logic [1:0] FMT_LIST  = 2'd1;
   localparam logic [1:0] FMT_RANGE = 2'd2;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = 1'b1;

   typedef struct packed {
      logic [GLYPH_W-1:0] first_glyph;
      logic [GLYPH_W-1:0] last_glyph;
      logic [GLYPH_W-1:0] base_index;
   } entry_type;

   typedef struct packed {
      logic               start;
      logic [1:0]         fmt;
      logic [GLYPH_W-1:0] glyph;
   } lkp_cmd_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_PROBE,
      STATE_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== src/gcil_table.sv =====
`default_nettype none

module gcil_table
   import gcil_pkg::*;
#(
   parameter int MAX_ENTRIES = GCIL_MAX_ENTRIES,
   parameter int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire entry_type         wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output entry_type              rd_data
);

   entry_type entry_mem [MAX_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/gcil_search.sv =====
`default_nettype none

`include "glyph_coverage_index_lookup_core_defines.svh"

module gcil_search
   import gcil_pkg::*;
#(
   parameter int MAX_ENTRIES = GCIL_MAX_ENTRIES,
   parameter int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lkp_cmd_type       cmd,
   input  wire logic [CNT_W-1:0]  count,
   output logic                   busy,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   input  wire entry_type         rd_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_found,
   output logic [COV_W-1:0]       rsp_coverage_index
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [CNT_W:0]     mid_sum;
   logic [GLYPH_W-1:0] glyph_ff, glyph_in;
   logic [1:0]         fmt_ff, fmt_in;
   logic               res_found_ff, res_found_in;
   logic [COV_W-1:0]   res_base_ff, res_base_in;
   logic [GLYPH_W-1:0] res_off_ff, res_off_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [COV_W-1:0]   rsp_cov_ff, rsp_cov_in;
   logic               below;
   logic               above;
   logic [GLYPH_W-1:0] upper_glyph;

   // shared compare unit
   assign upper_glyph = (fmt_ff == FMT_LIST) ? rd_data.first_glyph : rd_data.last_glyph;
   assign below       = glyph_ff < rd_data.first_glyph;
   assign above       = glyph_ff > upper_glyph;

   assign mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_in  = mid_sum[CNT_W:1];
   assign rd_addr = mid_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      glyph_ff     <= glyph_in;
      fmt_ff       <= fmt_in;
      res_found_ff <= res_found_in;
      res_base_ff  <= res_base_in;
      res_off_ff   <= res_off_in;
      rsp_found_ff <= rsp_found_in;
      rsp_cov_ff   <= rsp_cov_in;
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      glyph_in     = glyph_ff;
      fmt_in       = fmt_ff;
      res_found_in = res_found_ff;
      res_base_in  = res_base_ff;
      res_off_in   = res_off_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_cov_in   = rsp_cov_ff;
      rd_en        = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            if (cmd.start) begin
               glyph_in     = cmd.glyph;
               fmt_in       = cmd.fmt;
               lo_in        = '0;
               hi_in        = count;
               res_found_in = 1'b0;
               res_base_in  = '0;
               res_off_in   = '0;
               if ((cmd.fmt == FMT_LIST || cmd.fmt == FMT_RANGE) && count != '0) begin
                  rd_en    = 1'b1;
                  state_in = STATE_PROBE;
               end else begin
                  state_in = STATE_DONE;
               end
            end
         end
         STATE_PROBE: begin
            if (below) begin
               hi_in = mid_ff;
            end else if (above) begin
               lo_in = mid_ff + CNT_W'(1);
            end
            if (!below && !above) begin
               res_found_in = 1'b1;
               if (fmt_ff == FMT_LIST) begin
                  res_base_in = COV_W'(mid_ff);
                  res_off_in  = '0;
               end else begin
                  res_base_in = {1'b0, rd_data.base_index};
                  res_off_in  = glyph_ff - rd_data.first_glyph;
               end
               state_in = STATE_DONE;
            end else if (lo_in < hi_in) begin
               rd_en = 1'b1;
            end else begin
               state_in = STATE_DONE;
            end
         end
         STATE_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_cov_in   = res_base_ff + {1'b0, res_off_ff};
               state_in     = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   assign busy               = state_ff != STATE_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_coverage_index = rsp_cov_ff;

   `GCIL_ASSERT_IMP(a_probe_window, clock, reset, (state_ff == STATE_PROBE), ((lo_ff < hi_ff) && (mid_ff >= lo_ff) && (mid_ff < hi_ff)))
   `GCIL_ASSERT_IMP(a_miss_zero, clock, reset, (rsp_valid_ff && !rsp_found_ff), (rsp_cov_ff == '0))
   `GCIL_ASSERT_NXT(a_load_from_done, clock, reset, ((state_ff != STATE_DONE) && !rsp_valid_ff), (!rsp_valid_ff))

endmodule

`default_nettype wire

// ===== src/glyph_coverage_index_lookup_core.sv =====
// Write item: the write does not make the block busy, so a new request can follow straight away.
// Lookup item: the request is accepted in idle, then up to clog2(entry count)+1 table
// probes at one per cycle through the single read port, then the index is formed and
// registered in the done state, which waits while the response is stalled. Not ready during the search.
// Reset: synchronous, active high; format 1, count 0; table contents undefined.
`default_nettype none

module glyph_coverage_index_lookup_core
   import gcil_pkg::*;
#(
   parameter int MAX_ENTRIES = GCIL_MAX_ENTRIES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_command,
   input  wire logic [IDX_W-1:0]       req_entry_index,
   input  wire logic [GLYPH_W-1:0]     req_entry_first_glyph,
   input  wire logic [GLYPH_W-1:0]     req_entry_last_glyph,
   input  wire logic [GLYPH_W-1:0]     req_entry_base_index,
   input  wire logic [GLYPH_W-1:0]     req_glyph_id,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_found,
   output logic [COV_W-1:0]            rsp_coverage_index,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

   logic [1:0]            format_ff, format_in;
   logic [CSR_DATA_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]      count_sat;
   logic                  accept;
   logic                  busy;
   logic                  wr_en;
   logic [ADDR_W+IDX_W-1:0] wr_addr_ext;
   logic [ADDR_W-1:0]     wr_addr;
   entry_type             wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   entry_type             rd_data;
   lkp_cmd_type           cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      format_in = format_ff;
      count_in  = count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FORMAT: format_in = csr_wdata[1:0];
            CSR_COUNT:  count_in  = csr_wdata;
            default:    format_in = format_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_LIST;
         count_ff  <= '0;
      end else begin
         format_ff <= format_in;
         count_ff  <= count_in;
      end
   end

   assign count_sat = (32'(count_ff) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(count_ff);

   assign req_stall   = busy;
   assign accept      = req_valid && !req_stall;
   assign wr_en       = accept && (req_command == CMD_WRITE)
                        && (32'(req_entry_index) < 32'(MAX_ENTRIES));
   assign wr_addr_ext = (ADDR_W + IDX_W)'(req_entry_index);
   assign wr_addr     = wr_addr_ext[ADDR_W-1:0];

   assign wr_data.first_glyph = req_entry_first_glyph;
   assign wr_data.last_glyph  = req_entry_last_glyph;
   assign wr_data.base_index  = req_entry_base_index;

   assign cmd.start = accept && (req_command == CMD_LOOKUP);
   assign cmd.fmt   = format_ff;
   assign cmd.glyph = req_glyph_id;

   gcil_table #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_W      (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gcil_search #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_W      (ADDR_W),
      .CNT_W       (CNT_W)
   ) u_search (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .count              (count_sat),
      .busy               (busy),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_coverage_index (rsp_coverage_index)
   );

endmodule

`default_nettype wire
